FILE: rtl/core/fat16_cluster_chain_read_sequencer_unit_assert.svh
// Assertion macros used by the checker file of the FAT16 chain sequencer.
`ifndef FAT16_CLUSTER_CHAIN_READ_SEQUENCER_UNIT_ASSERT_SVH
`define FAT16_CLUSTER_CHAIN_READ_SEQUENCER_UNIT_ASSERT_SVH

// Clocked check, off while reset is asserted.
`define F16CS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// Clocked check that also holds while reset is asserted.
`define F16CS_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/f16cs_pkg.sv
// Package: types, codes and constants of the FAT16 chain sequencer.
package f16cs_pkg;

	localparam logic [1:0] KIND_FETCH  = 2'd0;
	localparam logic [1:0] KIND_COPY   = 2'd1;
	localparam logic [1:0] KIND_FINISH = 2'd2;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_BAD_START   = 3'd1;
	localparam logic [2:0] ST_MISMATCH    = 3'd2;
	localparam logic [2:0] ST_BAD_LINK    = 3'd3;
	localparam logic [2:0] ST_NOT_STARTED = 3'd4;

	localparam logic [2:0] REG_BPS = 3'd0;
	localparam logic [2:0] REG_SPC = 3'd1;
	localparam logic [2:0] REG_RES = 3'd2;
	localparam logic [2:0] REG_FC  = 3'd3;
	localparam logic [2:0] REG_SPT = 3'd4;
	localparam logic [2:0] REG_RE  = 3'd5;

	localparam logic [12:0] BPS_RST = 13'd512;
	localparam logic [7:0]  SPC_RST = 8'd4;
	localparam logic [15:0] RES_RST = 16'd1;
	localparam logic [1:0]  FC_RST  = 2'd2;
	localparam logic [15:0] SPT_RST = 16'd256;
	localparam logic [15:0] RE_RST  = 16'd512;

	localparam logic [20:0] CLUS_BYTES_RST = 21'd2048;
	localparam logic [31:0] RES_BYTES_RST  = 32'd512;
	localparam logic [31:0] FAT_BYTES_RST  = 32'd262144;
	localparam logic [20:0] DIR_BYTES_RST  = 21'd16384;

	localparam logic [15:0] MIN_CLUSTER = 16'd2;
	localparam logic [15:0] CHAIN_END   = 16'hfff7;
	localparam logic [31:0] BAD_TOTAL   = 32'hffffffff;

	typedef enum logic [1:0] {
		CMD_FIN,
		CMD_FETCH,
		CMD_COPY_FIN,
		CMD_COPY_FETCH
	} cmd_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [15:0] clus_a;
		logic [15:0] clus_b;
		logic [31:0] dest;
		logic [31:0] len;
		logic [31:0] total;
		logic [2:0]  status;
	} q_entry_t;

	typedef struct packed {
		logic [31:0] res_bytes;
		logic [31:0] fat_bytes;
		logic [20:0] dir_bytes;
		logic [20:0] clus_bytes;
	} geom_t;

endpackage

FILE: rtl/core/f16cs_cfg.sv
// Volume geometry registers and the byte sizes derived from them.
module f16cs_cfg import f16cs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output geom_t       geom
);

	logic [12:0] bps_q;
	logic [7:0]  spc_q;
	logic [15:0] res_q;
	logic [1:0]  fc_q;
	logic [15:0] spt_q;
	logic [15:0] re_q;

	logic [20:0] clus_bytes_q;
	logic [31:0] res_bytes_q;
	logic [31:0] fat_bytes_q;
	logic [20:0] dir_bytes_q;

	logic [20:0] clus_d;
	logic [28:0] res_d;
	logic [28:0] tbl_d;
	logic [30:0] fat_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bps_q <= BPS_RST;
			spc_q <= SPC_RST;
			res_q <= RES_RST;
			fc_q  <= FC_RST;
			spt_q <= SPT_RST;
			re_q  <= RE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BPS: bps_q <= cfg_data[12:0];
				REG_SPC: spc_q <= cfg_data[7:0];
				REG_RES: res_q <= cfg_data;
				REG_FC:  fc_q  <= cfg_data[1:0];
				REG_SPT: spt_q <= cfg_data;
				REG_RE:  re_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign clus_d = 21'(bps_q) * 21'(spc_q);
	assign res_d  = 29'(res_q) * 29'(bps_q);
	assign tbl_d  = 29'(spt_q) * 29'(bps_q);
	// fat_copies is two bits: shift-and-add instead of a second multiply
	assign fat_d  = ({1'b0, tbl_d, 1'b0} & {31{fc_q[1]}}) + ({2'b00, tbl_d} & {31{fc_q[0]}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clus_bytes_q <= CLUS_BYTES_RST;
			res_bytes_q  <= RES_BYTES_RST;
			fat_bytes_q  <= FAT_BYTES_RST;
			dir_bytes_q  <= DIR_BYTES_RST;
		end else begin
			clus_bytes_q <= clus_d;
			res_bytes_q  <= 32'(res_d);
			fat_bytes_q  <= 32'(fat_d);
			dir_bytes_q  <= {re_q, 5'b00000};
		end
	end

	assign geom.clus_bytes = clus_bytes_q;
	assign geom.res_bytes  = res_bytes_q;
	assign geom.fat_bytes  = fat_bytes_q;
	assign geom.dir_bytes  = dir_bytes_q;

endmodule

FILE: rtl/core/f16cs_front.sv
// Front end: accepts request words, tracks the chain walk and queues commands.
module f16cs_front import f16cs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        action,
	input  logic [15:0] cluster,
	input  logic [31:0] size_bytes,
	input  logic [20:0] clus_bytes,
	input  logic        full,
	output logic        push,
	output q_entry_t    push_entry
);

	logic        busy_q;
	logic [15:0] cur_q;
	logic [31:0] done_q;
	logic [31:0] wanted_q;

	logic        busy_d;
	logic [15:0] cur_d;
	logic [31:0] done_d;
	logic [31:0] wanted_d;
	logic [31:0] nd;

	assign req_stall = full;
	assign push      = req_valid && !full;
	assign nd        = done_q + 32'(clus_bytes);

	always_comb begin
		busy_d     = busy_q;
		cur_d      = cur_q;
		done_d     = done_q;
		wanted_d   = wanted_q;
		push_entry = '0;
		push_entry.cmd    = CMD_FIN;
		push_entry.status = ST_OK;
		if (!action) begin
			busy_d   = 1'b0;
			done_d   = '0;
			wanted_d = size_bytes;
			cur_d    = cluster;
			if (cluster < MIN_CLUSTER) begin
				push_entry.total  = BAD_TOTAL;
				push_entry.status = ST_BAD_START;
			end else if (size_bytes == '0) begin
				push_entry.total = '0;
			end else begin
				busy_d            = 1'b1;
				push_entry.cmd    = CMD_FETCH;
				push_entry.clus_a = cluster;
			end
		end else if (!busy_q) begin
			push_entry.status = ST_NOT_STARTED;
		end else if (cluster >= CHAIN_END) begin
			push_entry.cmd    = CMD_COPY_FIN;
			push_entry.clus_a = cur_q;
			push_entry.dest   = done_q;
			push_entry.len    = wanted_q - done_q;
			push_entry.total  = wanted_q;
			done_d = wanted_q;
			busy_d = 1'b0;
		end else begin
			done_d = nd;
			push_entry.clus_a = cur_q;
			push_entry.dest   = done_q;
			push_entry.len    = 32'(clus_bytes);
			push_entry.total  = nd;
			if (nd >= wanted_q) begin
				push_entry.cmd    = CMD_COPY_FIN;
				push_entry.status = (nd == wanted_q) ? ST_OK : ST_MISMATCH;
				busy_d = 1'b0;
			end else if (cluster < MIN_CLUSTER) begin
				push_entry.cmd    = CMD_COPY_FIN;
				push_entry.status = ST_BAD_LINK;
				busy_d = 1'b0;
			end else begin
				push_entry.cmd    = CMD_COPY_FETCH;
				push_entry.clus_b = cluster;
				cur_d = cluster;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			cur_q    <= '0;
			done_q   <= '0;
			wanted_q <= '0;
		end else if (push) begin
			busy_q   <= busy_d;
			cur_q    <= cur_d;
			done_q   <= done_d;
			wanted_q <= wanted_d;
		end
	end

endmodule

FILE: rtl/core/f16cs_fifo.sv
// Command queue between the front end and the back end.
module f16cs_fifo import f16cs_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_entry,
	output logic     full,
	input  logic     pop,
	output q_entry_t head,
	output logic     empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	q_entry_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign full  = (cnt_q == FULL_CNT);
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/f16cs_back.sv
// Back end: turns queued commands into result words with volume addresses.
module f16cs_back import f16cs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  geom_t       geom,
	input  q_entry_t    head,
	input  logic        empty,
	output logic        pop,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  kind,
	output logic [31:0] address,
	output logic [31:0] dest_offset,
	output logic [31:0] length,
	output logic [2:0]  status,
	output logic        last
);

	cmd_t        cmd_s1;
	logic        valid_s1;
	logic        phase_q;
	logic [31:0] dest_s1;
	logic [31:0] len_s1;
	logic [31:0] total_s1;
	logic [2:0]  status_s1;
	logic [31:0] faddr_s1;
	logic [31:0] base_s1;
	logic [31:0] prod_s1;

	logic        rsp_valid_q;
	logic [1:0]  kind_q;
	logic [31:0] address_q;
	logic [31:0] dest_q;
	logic [31:0] length_q;
	logic [2:0]  status_q;
	logic        last_q;

	logic        two_words;
	logic        word_move;
	logic        s1_done;
	logic [15:0] clus_sel;
	logic [15:0] clus_off;
	logic [36:0] prod_full;

	logic [1:0]  w_kind;
	logic [31:0] w_addr;
	logic [31:0] w_dest;
	logic [31:0] w_len;
	logic [2:0]  w_status;
	logic        w_last;

	assign two_words = (cmd_s1 == CMD_COPY_FIN) || (cmd_s1 == CMD_COPY_FETCH);
	assign word_move = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign s1_done   = word_move && (!two_words || phase_q);
	assign pop       = !empty && (!valid_s1 || s1_done);

	assign clus_sel  = (head.cmd == CMD_FETCH) ? head.clus_a : head.clus_b;
	assign clus_off  = head.clus_a - MIN_CLUSTER;
	assign prod_full = 37'(clus_off) * 37'(geom.clus_bytes);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (s1_done) begin
				valid_s1 <= 1'b0;
			end
			if (pop || s1_done) begin
				phase_q <= 1'b0;
			end else if (word_move) begin
				phase_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s1    <= head.cmd;
			dest_s1   <= head.dest;
			len_s1    <= head.len;
			total_s1  <= head.total;
			status_s1 <= head.status;
			faddr_s1  <= geom.res_bytes + {15'b0, clus_sel, 1'b0};
			base_s1   <= geom.res_bytes + geom.fat_bytes + {11'b0, geom.dir_bytes};
			prod_s1   <= prod_full[31:0];
		end
	end

	always_comb begin
		w_kind   = KIND_FINISH;
		w_addr   = '0;
		w_dest   = total_s1;
		w_len    = '0;
		w_status = status_s1;
		w_last   = 1'b1;
		case (cmd_s1)
			CMD_FIN: ;
			CMD_FETCH: begin
				w_kind   = KIND_FETCH;
				w_addr   = faddr_s1;
				w_dest   = '0;
				w_status = ST_OK;
			end
			CMD_COPY_FIN, CMD_COPY_FETCH: begin
				if (!phase_q) begin
					w_kind   = KIND_COPY;
					w_addr   = base_s1 + prod_s1;
					w_dest   = dest_s1;
					w_len    = len_s1;
					w_status = ST_OK;
					w_last   = 1'b0;
				end else if (cmd_s1 == CMD_COPY_FETCH) begin
					w_kind   = KIND_FETCH;
					w_addr   = faddr_s1;
					w_dest   = '0;
					w_status = ST_OK;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (word_move) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (word_move) begin
			kind_q    <= w_kind;
			address_q <= w_addr;
			dest_q    <= w_dest;
			length_q  <= w_len;
			status_q  <= w_status;
			last_q    <= w_last;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign kind        = kind_q;
	assign address     = address_q;
	assign dest_offset = dest_q;
	assign length      = length_q;
	assign status      = status_q;
	assign last        = last_q;

endmodule

FILE: rtl/core/fat16_cluster_chain_read_sequencer_unit.sv
// FAT16 cluster chain read sequencer, top level.
// A start word (action 0) carries the first cluster and the file size; each
// returned FAT entry (action 1) advances the walk. The front end takes one
// request word per cycle, updates the walk state at once and queues a command,
// so it stalls only when the command queue (QUEUE_DEPTH entries) is full. The
// back end emits one result word per cycle while the output is not stalled: a
// start or an entry returned while idle yields one word, a returned entry during
// a read yields two (copy, then fetch or finish), and the next command is taken
// only as the second word moves out. A result passes through the queue, the
// address product stage and the output register. A geometry write goes through
// the geometry register and then the registered byte sizes derived from it.
module fat16_cluster_chain_read_sequencer_unit import f16cs_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        action,
	input  logic [15:0] cluster,
	input  logic [31:0] size_bytes,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  kind,
	output logic [31:0] address,
	output logic [31:0] dest_offset,
	output logic [31:0] length,
	output logic [2:0]  status,
	output logic        last
);

	geom_t    geom;
	q_entry_t push_entry;
	q_entry_t head;
	logic     push;
	logic     pop;
	logic     full;
	logic     empty;

	f16cs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom)
	);

	f16cs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.action     (action),
		.cluster    (cluster),
		.size_bytes (size_bytes),
		.clus_bytes (geom.clus_bytes),
		.full       (full),
		.push       (push),
		.push_entry (push_entry)
	);

	f16cs_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.empty      (empty)
	);

	f16cs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.geom        (geom),
		.head        (head),
		.empty       (empty),
		.pop         (pop),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.kind        (kind),
		.address     (address),
		.dest_offset (dest_offset),
		.length      (length),
		.status      (status),
		.last        (last)
	);

endmodule

FILE: rtl/core/f16cs_chk.sv
// Port-level checker for the FAT16 chain sequencer and its bind.
`include "fat16_cluster_chain_read_sequencer_unit_assert.svh"

module f16cs_chk import f16cs_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [1:0]  kind,
	input logic [31:0] address,
	input logic [31:0] dest_offset,
	input logic [31:0] length,
	input logic [2:0]  status,
	input logic        last
);

	`F16CS_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid, "rsp word dropped while stalled")
	`F16CS_ASSERT(a_rsp_stable, rsp_valid && rsp_stall |=> $stable(kind) && $stable(address) && $stable(dest_offset) && $stable(length) && $stable(status) && $stable(last), "rsp word changed while stalled")
	`F16CS_ASSERT(a_not_last_copy, rsp_valid && !last |-> kind == KIND_COPY && status == ST_OK, "only an ok copy word may be followed by another")
	`F16CS_ASSERT(a_finish_zero, rsp_valid && kind == KIND_FINISH |-> address == '0 && length == '0, "finish word with address or length")
	`F16CS_ASSERT_RST(a_rst_quiet, !arst_n |-> !rsp_valid, "rsp valid during reset")

endmodule

bind fat16_cluster_chain_read_sequencer_unit f16cs_chk u_chk (.*);
